// File: hdl/vdlb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdlb_pkg
// Shared constants, register codes and conversion tables for the directional
// light vertex bake pipeline.
// ----------------------------------------------------------------------------
package vdlb_pkg;

    // Configuration register indexes
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_DIR    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AMBIENT_RGB  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_RGB    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_AMBIENT_STR  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_STR    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_MULT   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_USE_SRGB     = 3'd6;

    localparam logic [15:0] ONE_UQ412 = 16'd4096;

    // Light level after the white blend: 0 .. 2^24 (1.0 in Q.24)
    localparam int LVL_W = 25;

    typedef logic [LVL_W-1:0]              level_t;
    typedef logic [255:0][LVL_W-1:0]       srgb_tab_t;
    typedef logic [15:0][LVL_W-1:0]        lin_tab_t;

    // Largest level that still takes the linear toe of the sRGB curve
    localparam level_t SRGB_LIN_MAX = LVL_W'((64'd31308 << 24) / 64'd10000000);

    // Channel times strength, rounded half up, saturated to UQ4.12
    function automatic logic [15:0] scale_color(input logic [15:0] c, input logic [15:0] s);
        logic [32:0] p;
        p = 33'(c) * 33'(s) + 33'd2048;
        return (|p[32:28]) ? 16'hFFFF : p[27:12];
    endfunction

    // Smallest level whose sRGB code reaches k, decided exactly:
    // v^5 * 53805^12 >= (200k + 2705)^12 * 2^120
    function automatic srgb_tab_t build_srgb_tab();
        logic [319:0] cpow;
        logic [319:0] rhs;
        logic [319:0] base;
        logic [319:0] lhs;
        logic [319:0] c2;
        level_t       thr;
        level_t       cand;
        srgb_tab_t    tab;
        tab  = '0;
        cpow = 320'd1;
        for (int i = 0; i < 12; i++) begin
            cpow = cpow * 320'd53805;
        end
        for (int k = 1; k < 256; k++) begin
            base = 320'(200 * k + 2705);
            rhs  = 320'd1;
            for (int i = 0; i < 12; i++) begin
                rhs = rhs * base;
            end
            rhs = rhs << 120;
            thr = '0;
            for (int b = LVL_W - 1; b >= 0; b--) begin
                cand = thr | (LVL_W'(1) << b);
                c2   = 320'(cand) * 320'(cand);
                lhs  = c2 * c2 * 320'(cand) * cpow;
                if (lhs < rhs) begin
                    thr = cand;
                end
            end
            tab[k] = thr + LVL_W'(1);
        end
        return tab;
    endfunction

    // Smallest level whose linear-toe code (12.92 * x * 255, rounded) reaches j
    function automatic lin_tab_t build_lin_tab();
        lin_tab_t tab;
        tab = '0;
        for (int j = 1; j < 16; j++) begin
            tab[j] = LVL_W'(((64'(10 * j - 5) << 24) + 64'd32945) / 64'd32946);
        end
        return tab;
    endfunction

    localparam srgb_tab_t SRGB_TAB     = build_srgb_tab();
    localparam lin_tab_t  SRGB_LIN_TAB = build_lin_tab();

endpackage

// File: hdl/vertex_directional_light_bake.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_directional_light_bake
// Per-vertex Lambert diffuse color bake from one directional light and an
// ambient term, with linear or sRGB 8-bit output.
// ----------------------------------------------------------------------------
// Takes one vertex normal per cycle while s_tready is high and returns one
// RGBA8 color per normal, in order. The pipeline depth comes from six
// arithmetic stages (dot product, influence, two color blends, white blend,
// clamp) followed by an eight-step search of the sRGB threshold table, one
// bit of the code per stage. Each stage holds its item only while the stage
// ahead is full, so bubbles close up and the input keeps taking items while a
// result waits at the output, until all stages are full. Configuration writes
// are accepted every cycle; each stage reads the setting it uses, so items in
// flight can see a write. The scaled ambient and light colors follow their
// registers in the next cycle. No clearing pass follows reset.
// ----------------------------------------------------------------------------
module vertex_directional_light_bake (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [47:0]                      s_tdata,    // normal_x, normal_y, normal_z
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [31:0]                      m_tdata,    // red, green, blue, alpha
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [vdlb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [vdlb_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import vdlb_pkg::*;

    localparam int NSTG    = 14;
    localparam int NSRCH   = 7;
    localparam int SRCH0   = 6;
    localparam int OUT_STG = NSTG - 1;

    // Configuration
    logic [47:0] light_dir_reg;
    logic [47:0] ambient_rgb_reg;
    logic [47:0] light_rgb_reg;
    logic [15:0] ambient_str_reg;
    logic [15:0] light_str_reg;
    logic [15:0] light_mult_reg;
    logic        use_srgb_reg;
    logic [15:0] amb_s_reg [3];
    logic [15:0] lit_s_reg [3];

    // Pipeline control
    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] vld_next;
    logic [NSTG-1:0] en;

    // Stage payloads
    logic signed [31:0] prod_reg  [3];
    logic signed [31:0] prod_next [3];
    logic [15:0]        t_reg;
    logic [15:0]        t_next;
    logic [31:0]        ma_reg    [3];
    logic [31:0]        ml_reg    [3];
    logic [31:0]        ma_next   [3];
    logic [31:0]        ml_next   [3];
    logic [15:0]        c_reg     [3];
    logic [15:0]        c_next    [3];
    logic signed [33:0] cm_reg    [3];
    logic signed [33:0] cm_next   [3];
    level_t             v_reg     [3];
    level_t             v_next    [3];

    logic [7:0]  srch_k_reg   [NSRCH][3];
    level_t      srch_v_reg   [NSRCH][3];
    logic [3:0]  srch_lc_reg  [NSRCH][3];
    logic        srch_low_reg [NSRCH][3];
    logic [7:0]  srch_k_next  [NSRCH][3];
    logic [7:0]  srch_kin     [NSRCH][3];
    level_t      srch_vin     [NSRCH][3];
    logic [3:0]  lc_next      [3];

    logic [7:0]  byte_next    [3];
    logic [31:0] out_reg;

    logic signed [33:0] dot;
    logic signed [33:0] neg;
    logic [31:0]        t_round;

    // ------------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            light_dir_reg   <= '0;
            ambient_rgb_reg <= '0;
            light_rgb_reg   <= '0;
            ambient_str_reg <= ONE_UQ412;
            light_str_reg   <= ONE_UQ412;
            light_mult_reg  <= ONE_UQ412;
            use_srgb_reg    <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_LIGHT_DIR:   light_dir_reg   <= cfg_data;
                REG_AMBIENT_RGB: ambient_rgb_reg <= cfg_data;
                REG_LIGHT_RGB:   light_rgb_reg   <= cfg_data;
                REG_AMBIENT_STR: ambient_str_reg <= cfg_data[15:0];
                REG_LIGHT_STR:   light_str_reg   <= cfg_data[15:0];
                REG_LIGHT_MULT:  light_mult_reg  <= cfg_data[15:0];
                REG_USE_SRGB:    use_srgb_reg    <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Scaled colors depend on configuration only; refresh every cycle
    always_ff @(posedge aclk) begin
        for (int c = 0; c < 3; c++) begin
            amb_s_reg[c] <= scale_color(ambient_rgb_reg[16*c +: 16], ambient_str_reg);
            lit_s_reg[c] <= scale_color(light_rgb_reg[16*c +: 16], light_str_reg);
        end
    end

    // ------------------------------------------------------------------------
    // Stage enables: a stage loads when it is empty or the next one loads
    // ------------------------------------------------------------------------
    always_comb begin
        en[OUT_STG] = !vld_reg[OUT_STG] || m_tready;
        for (int i = OUT_STG - 1; i >= 0; i--) begin
            en[i] = !vld_reg[i] || en[i+1];
        end
        vld_next = vld_reg;
        for (int i = 0; i < NSTG; i++) begin
            if (en[i]) begin
                vld_next[i] = (i == 0) ? s_tvalid : vld_reg[(i == 0) ? 0 : i - 1];
            end
        end
    end

    assign s_tready = en[0];
    assign m_tvalid = vld_reg[OUT_STG];
    assign m_tdata  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    // ------------------------------------------------------------------------
    // Datapath
    // ------------------------------------------------------------------------
    always_comb begin
        // products of normal and direction
        for (int c = 0; c < 3; c++) begin
            prod_next[c] = 32'($signed(s_tdata[16*c +: 16]))
                         * 32'($signed(light_dir_reg[16*c +: 16]));
        end

        // influence: negated dot, clamped to 0..1, rounded to Q1.15
        dot     = 34'(prod_reg[0]) + 34'(prod_reg[1]) + 34'(prod_reg[2]);
        neg     = -dot;
        t_round = {1'b0, neg[30:0]} + 32'd16384;
        if (neg[33] || (neg == '0)) begin
            t_next = '0;
        end else if (neg > 34'sd1073741824) begin
            t_next = 16'd32768;
        end else begin
            t_next = t_round[30:15];
        end

        for (int c = 0; c < 3; c++) begin
            ma_next[c] = 32'(amb_s_reg[c]) * 32'(17'd32768 - 17'(t_reg));
            ml_next[c] = 32'(lit_s_reg[c]) * 32'(t_reg);
            c_next[c]  = 16'((33'(ma_reg[c]) + 33'(ml_reg[c]) + 33'd16384) >> 15);
            cm_next[c] = 34'($signed({1'b0, c_reg[c]} - {1'b0, ONE_UQ412}))
                       * 34'($signed({1'b0, light_mult_reg}));
            // white blend, clamp to 0..1.0
            if (cm_reg[c] < -34'sd16777216) begin
                v_next[c] = '0;
            end else if (cm_reg[c] > 34'sd0) begin
                v_next[c] = LVL_W'(1) << 24;
            end else begin
                v_next[c] = LVL_W'(35'sd16777216 + 35'(cm_reg[c]));
            end
        end

        // linear toe code and threshold search, one code bit a stage
        for (int c = 0; c < 3; c++) begin
            lc_next[c] = '0;
            for (int j = 1; j < 16; j++) begin
                if (v_reg[c] >= SRGB_LIN_TAB[4'(j)]) begin
                    lc_next[c] = 4'(j);
                end
            end
            srch_kin[0][c] = '0;
            srch_vin[0][c] = v_reg[c];
            for (int j = 1; j < NSRCH; j++) begin
                srch_kin[j][c] = srch_k_reg[j-1][c];
                srch_vin[j][c] = srch_v_reg[j-1][c];
            end
            for (int j = 0; j < NSRCH; j++) begin
                srch_k_next[j][c] =
                    (srch_vin[j][c] >= SRGB_TAB[srch_kin[j][c] | (8'd128 >> j)])
                    ? (srch_kin[j][c] | (8'd128 >> j)) : srch_kin[j][c];
            end
        end

        // last code bit and output select
        for (int c = 0; c < 3; c++) begin
            if (!use_srgb_reg) begin
                byte_next[c] = 8'((33'(srch_v_reg[NSRCH-1][c]) * 33'd255 + 33'd8388608) >> 24);
            end else if (srch_low_reg[NSRCH-1][c]) begin
                byte_next[c] = {4'd0, srch_lc_reg[NSRCH-1][c]};
            end else if (srch_v_reg[NSRCH-1][c] >= SRGB_TAB[srch_k_reg[NSRCH-1][c] | 8'd1]) begin
                byte_next[c] = srch_k_reg[NSRCH-1][c] | 8'd1;
            end else begin
                byte_next[c] = srch_k_reg[NSRCH-1][c];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            prod_reg <= prod_next;
        end
        if (en[1]) begin
            t_reg <= t_next;
        end
        if (en[2]) begin
            ma_reg <= ma_next;
            ml_reg <= ml_next;
        end
        if (en[3]) begin
            c_reg <= c_next;
        end
        if (en[4]) begin
            cm_reg <= cm_next;
        end
        if (en[5]) begin
            v_reg <= v_next;
        end
        for (int j = 0; j < NSRCH; j++) begin
            if (en[SRCH0 + j]) begin
                for (int c = 0; c < 3; c++) begin
                    srch_k_reg[j][c] <= srch_k_next[j][c];
                    srch_v_reg[j][c] <= srch_vin[j][c];
                    srch_lc_reg[j][c]  <= (j == 0) ? lc_next[c]
                                        : srch_lc_reg[(j == 0) ? 0 : j - 1][c];
                    srch_low_reg[j][c] <= (j == 0) ? (v_reg[c] <= SRGB_LIN_MAX)
                                        : srch_low_reg[(j == 0) ? 0 : j - 1][c];
                end
            end
        end
        if (en[OUT_STG]) begin
            out_reg <= {8'hFF, byte_next[2], byte_next[1], byte_next[0]};
        end
    end

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (&vld_reg) && !m_tready)
        else $error("input stalled with room in the pipeline");

    a_influence_range: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[1] |-> t_reg <= 16'd32768)
        else $error("influence above 1.0");

    a_level_range: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[5] |-> (v_reg[0] <= (LVL_W'(1) << 24)) && (v_reg[1] <= (LVL_W'(1) << 24))
                    && (v_reg[2] <= (LVL_W'(1) << 24)))
        else $error("light level outside 0..1.0");

    a_alpha_opaque: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[31:24] == 8'hFF)
        else $error("alpha not opaque");

    a_output_advances: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[OUT_STG-1] && en[OUT_STG] |=> m_tvalid)
        else $error("item lost before output stage");

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the directional light vertex bake block. Vertex
// normals are streamed in bursts while the output side stalls on a changing
// pattern. An independent integer model of the Lambert bake, including the
// exact sRGB code search, predicts one RGBA8 color per accepted normal, and
// every returned color is checked channel by channel in order. Register
// settings change between phases, only while the pipeline is empty.
// ----------------------------------------------------------------------------
module tb_top;
    import vdlb_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int PIPE_LATENCY = 14;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [47:0]           s_tdata;     // normal_x, normal_y, normal_z
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [31:0]           m_tdata;     // red, green, blue, alpha
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Bake settings as the block should hold them
    logic [47:0] light_dir;
    logic [47:0] amb_rgb;
    logic [47:0] lit_rgb;
    logic [15:0] amb_str;
    logic [15:0] lit_str;
    logic [15:0] lit_mult;
    logic        srgb_on;

    logic [31:0] pending_colors[$];
    logic [31:0] oldest_color;
    logic [31:0] missing_color;
    string       channel_names[4] = '{"red", "green", "blue", "alpha"};

    int error_count;
    int items_sent;
    int colors_checked;
    int settings_loaded;
    int burst_left;
    int stall_mode = 0;
    int cycle_count = 0;

    vertex_directional_light_bake dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Lambert bake of one normal into RGBA8, red in the low byte
    function automatic logic [31:0] bake_color(input logic [47:0] nrm);
        longint      dot;
        longint      neg;
        longint      t;
        longint      a;
        longint      l;
        longint      c;
        longint      v;
        longint      code;
        int          lo;
        int          hi;
        int          mid;
        logic [319:0] lhs;
        logic [319:0] rhs;
        logic [319:0] base;
        logic [31:0] rgba;
        dot = 0;
        for (int i = 0; i < 3; i++) begin
            dot += longint'($signed(nrm[16*i +: 16])) *
                   longint'($signed(light_dir[16*i +: 16]));
        end
        neg = -dot;
        if (neg < 0) neg = 0;
        if (neg > (longint'(1) << 30)) neg = longint'(1) << 30;
        t = (neg + 16384) >> 15;
        rgba[31:24] = 8'hFF;
        for (int i = 0; i < 3; i++) begin
            a = (longint'(amb_rgb[16*i +: 16]) * longint'(amb_str) + 2048) >> 12;
            l = (longint'(lit_rgb[16*i +: 16]) * longint'(lit_str) + 2048) >> 12;
            if (a > 65535) a = 65535;
            if (l > 65535) l = 65535;
            c = (a * (32768 - t) + l * t + 16384) >> 15;
            v = (longint'(1) << 24) + (c - 4096) * longint'(lit_mult);
            if (v < 0) v = 0;
            if (v > (longint'(1) << 24)) v = longint'(1) << 24;
            if (!srgb_on) begin
                code = (v * 255 + (longint'(1) << 23)) >> 24;
            end else if (v * 10000000 <= (longint'(31308) << 24)) begin
                // linear toe of the sRGB curve
                code = (v * 32946 + (longint'(5) << 24)) / (longint'(10) << 24);
            end else begin
                // largest k with v^5 * 53805^12 >= (200k + 2705)^12 * 2^120
                lhs = 320'd1;
                for (int j = 0; j < 5; j++) lhs = lhs * 320'(v);
                for (int j = 0; j < 12; j++) lhs = lhs * 320'd53805;
                lo = 0;
                hi = 255;
                while (lo < hi) begin
                    mid  = (lo + hi + 1) >> 1;
                    base = 320'(200 * mid + 2705);
                    rhs  = 320'd1;
                    for (int j = 0; j < 12; j++) rhs = rhs * base;
                    rhs = rhs << 120;
                    if (lhs >= rhs) lo = mid;
                    else hi = mid - 1;
                end
                code = lo;
            end
            rgba[8*i +: 8] = code[7:0];
        end
        return rgba;
    endfunction

    function automatic logic [15:0] pick_uq412();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'($urandom());
            default: return 16'($urandom_range(0, 8192));
        endcase
    endfunction

    function automatic logic [15:0] pick_q115();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic logic [15:0] pick_component();
        case ($urandom_range(0, 9))
            6, 7: begin
                case ($urandom_range(0, 4))
                    0: return 16'h8000;
                    1: return 16'h7FFF;
                    2: return 16'h0000;
                    3: return 16'hFFFF;
                    default: return 16'h0001;
                endcase
            end
            8, 9: return 16'($signed($urandom_range(0, 2000)) - 1000);
            default: return 16'($urandom());
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= 40) $display("[%0t] MISMATCH %s", $time, msg);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            REG_LIGHT_DIR:   light_dir = data[47:0];
            REG_AMBIENT_RGB: amb_rgb   = data[47:0];
            REG_LIGHT_RGB:   lit_rgb   = data[47:0];
            REG_AMBIENT_STR: amb_str   = data[15:0];
            REG_LIGHT_STR:   lit_str   = data[15:0];
            REG_LIGHT_MULT:  lit_mult  = data[15:0];
            REG_USE_SRGB:    srgb_on   = data[0];
            default: ;
        endcase
    endtask

    // Write every register, plus one unused index that must be ignored
    task automatic load_settings(input logic [47:0] dir, input logic [47:0] amb,
                                 input logic [47:0] lit, input logic [15:0] astr,
                                 input logic [15:0] lstr, input logic [15:0] mult,
                                 input logic srgb);
        write_reg(REG_LIGHT_DIR, dir);
        write_reg(REG_UNUSED, {$urandom(), 16'($urandom())});
        write_reg(REG_AMBIENT_RGB, amb);
        write_reg(REG_LIGHT_RGB, lit);
        write_reg(REG_AMBIENT_STR, {$urandom(), astr});
        write_reg(REG_LIGHT_STR, {$urandom(), lstr});
        write_reg(REG_LIGHT_MULT, {$urandom(), mult});
        write_reg(REG_USE_SRGB, {$urandom(), 15'($urandom()), srgb});
        cfg_valid <= 1'b0;
        settings_loaded++;
    endtask

    // Send one normal; open a new burst with a random gap when the last one ends
    task automatic send_normal(input logic [47:0] nrm);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= nrm;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_colors.push_back(bake_color(nrm));
        items_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_colors.size() != 0);
    endtask

    task automatic test_reset_values();
        send_normal({16'h7FFF, 16'h7FFF, 16'h7FFF});
        send_normal({16'h8000, 16'h8000, 16'h8000});
        send_normal(48'h0);
        drain();
    endtask

    task automatic test_directed_cases();
        // overbright colors saturate, multiplier above one overshoots,
        // unnormalized vectors drive the influence into its clamp
        load_settings({3{16'h8000}}, {16'hFFFF, 16'h2000, 16'h0000},
                      {16'h0000, 16'h0800, 16'hFFFF}, 16'hFFFF, 16'h1000,
                      16'hFFFF, 1'b0);
        send_normal({16'h7FFF, 16'h7FFF, 16'h7FFF});
        send_normal({16'h8000, 16'h8000, 16'h8000});
        send_normal({16'h0000, 16'h0000, 16'h4000});
        send_normal(48'h0);
        drain();
        // sRGB: linear toe on dim channels, curve above it
        load_settings({16'h0000, 16'h0000, 16'h7FFF}, {16'd13, 16'd12, 16'd1},
                      {16'd0, 16'd2048, 16'd4096}, 16'h1000, 16'h1000,
                      16'h1000, 1'b1);
        send_normal(48'h0);
        send_normal({16'h0000, 16'h0000, 16'h8000});
        send_normal({16'h0000, 16'h0000, 16'hC000});
        send_normal({16'h0000, 16'hFFFF, 16'h7FFF});
        send_normal({16'h7FFF, 16'h8000, 16'hFFFF});
        send_normal({16'h0000, 16'h0000, 16'hFFFF});
        drain();
        // zero multiplier gives white
        load_settings({16'h1234, 16'h8000, 16'h7FFF}, {3{16'h0800}},
                      {3{16'h0400}}, 16'h0000, 16'hFFFF, 16'h0000, 1'b1);
        send_normal({16'h8000, 16'h7FFF, 16'h8000});
        send_normal(48'h0);
        drain();
        // half multiplier, linear
        load_settings({16'h0000, 16'hA000, 16'h6000}, {16'h0100, 16'h0800, 16'h1000},
                      {16'h3000, 16'h1000, 16'h0000}, 16'h0800, 16'h2000,
                      16'h0800, 1'b0);
        send_normal({16'h0000, 16'h6000, 16'hA000});
        send_normal({16'h0000, 16'hA000, 16'h6000});
        send_normal({16'h0000, 16'h2D41, 16'hD2BF});
        send_normal({16'hFFFF, 16'hFFFF, 16'hFFFF});
        drain();
    endtask

    task automatic test_random_settings();
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: load_settings({48{1'b1}}, {48{1'b1}}, {48{1'b1}}, 16'hFFFF,
                                 16'hFFFF, 16'hFFFF, 1'b1);
                1: load_settings(48'h0, 48'h0, 48'h0, 16'h0000, 16'h0000,
                                 16'h0000, 1'b0);
                default: load_settings({pick_q115(), pick_q115(), pick_q115()},
                                       {pick_uq412(), pick_uq412(), pick_uq412()},
                                       {pick_uq412(), pick_uq412(), pick_uq412()},
                                       pick_uq412(), pick_uq412(), pick_uq412(),
                                       1'($urandom()));
            endcase
            repeat (175) begin
                send_normal({pick_component(), pick_component(), pick_component()});
            end
            drain();
        end
    endtask

    // Output side: stall pattern picked anew when the low byte of the cycle counter is zero; also result checking
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count[7:0] == 8'd0) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 3) != 0);
            2: m_tready <= (cycle_count[2:0] != 3'd5) && (cycle_count[4:3] != 2'd2);
            default: m_tready <= ($urandom_range(0, 9) == 0);
        endcase
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_colors.size() == 0) begin
                report_mismatch($sformatf("color %h with none expected", m_tdata));
            end else begin
                oldest_color = pending_colors.pop_front();
                colors_checked++;
                for (int i = 0; i < 4; i++) begin
                    if (m_tdata[8*i +: 8] !== oldest_color[8*i +: 8]) begin
                        report_mismatch($sformatf("color %0d %s: got %0d, expected %0d",
                            colors_checked, channel_names[i], m_tdata[8*i +: 8],
                            oldest_color[8*i +: 8]));
                    end
                end
            end
        end
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        aresetn         = 1'b0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        cfg_valid       = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        light_dir       = '0;
        amb_rgb         = '0;
        lit_rgb         = '0;
        amb_str         = ONE_UQ412;
        lit_str         = ONE_UQ412;
        lit_mult        = ONE_UQ412;
        srgb_on         = 1'b0;
        error_count     = 0;
        items_sent      = 0;
        colors_checked  = 0;
        settings_loaded = 0;
        burst_left      = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_values();
        test_directed_cases();
        test_random_settings();

        drain();
        repeat (PIPE_LATENCY + 10) @(posedge aclk);
        while (pending_colors.size() != 0) begin
            missing_color = pending_colors.pop_front();
            report_mismatch($sformatf("expected color %h never arrived", missing_color));
        end

        $display("Baked %0d normals under %0d register settings, linear and sRGB",
                 items_sent, settings_loaded);
        $display("Checked %0d colors, %0d mismatches", colors_checked, error_count);
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// File: filelist.f
hdl/vdlb_pkg.sv
hdl/vertex_directional_light_bake.sv
bench/tb_top.sv
